### src/threshold_peak_detector_top_assert.svh
// Assertion macros for the threshold peak detector.
`ifndef THRESHOLD_PEAK_DETECTOR_TOP_ASSERT_SVH
`define THRESHOLD_PEAK_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpd assertion failed");

// Next-cycle implication, checked outside reset.
`define TPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpd assertion failed");

`endif

### src/tpd_pkg.sv
// Package: widths, constants and shared types of the threshold peak detector.
package tpd_pkg;

	localparam int BUFFER_DEPTH   = 16384;
	localparam int PEAK_LIMIT_MAX = 64;

	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 14;
	localparam int CNT_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int IDX_CAP_INT = (BUFFER_DEPTH - 1 > 16383) ? 16383 : BUFFER_DEPTH - 1;
	localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_INT);
	localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(PEAK_LIMIT_MAX);
	localparam logic [CNT_W-1:0] PEAK_QUOTA_RST = CNT_W'(64);

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_THR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_QUOTA    = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] height_thr;
		logic [IDX_W-1:0]           min_run_width;
		logic [CNT_W-1:0]           peak_quota;
	} cfg_t;

	typedef struct packed {
		logic             peak_found;
		logic [IDX_W-1:0] peak_center;
		logic [IDX_W-1:0] peak_width;
		logic [CNT_W-1:0] peak_count;
		logic             limit_reached;
		logic             frame_end;
	} result_t;

endpackage

### src/tpd_if.sv
// Handshake interfaces for the sample and peak result channels.
interface tpd_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [tpd_pkg::SAMPLE_W-1:0] sample;
	logic                                last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface tpd_peak_if;
	logic                          valid;
	logic                          ready;
	logic                          peak_found;
	logic [tpd_pkg::IDX_W-1:0]     peak_center;
	logic [tpd_pkg::IDX_W-1:0]     peak_width;
	logic [tpd_pkg::CNT_W-1:0]     peak_count;
	logic                          limit_reached;
	logic                          frame_end;

	modport source (output valid, output peak_found, output peak_center, output peak_width,
		output peak_count, output limit_reached, output frame_end, input ready);
	modport sink (input valid, input peak_found, input peak_center, input peak_width,
		input peak_count, input limit_reached, input frame_end, output ready);
endinterface

### src/tpd_cfg.sv
// Configuration register file of the threshold peak detector.
module tpd_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output tpd_pkg::cfg_t                      cfg
);

	tpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_thr    <= '0;
			cfg_q.min_run_width <= '0;
			cfg_q.peak_quota    <= tpd_pkg::PEAK_QUOTA_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tpd_pkg::REG_HEIGHT_THR:    cfg_q.height_thr    <= cfg_wdata;
				tpd_pkg::REG_MIN_RUN_WIDTH: cfg_q.min_run_width <= cfg_wdata[tpd_pkg::IDX_W-1:0];
				tpd_pkg::REG_PEAK_QUOTA:    cfg_q.peak_quota    <= cfg_wdata[tpd_pkg::CNT_W-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/tpd_detect.sv
// Run tracking, peak acceptance and frame state of the peak detector.
module tpd_detect (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tpd_pkg::cfg_t                      cfg,
	input  logic                               fire,
	input  logic signed [tpd_pkg::SAMPLE_W-1:0] sample,
	input  logic                               last_sample,
	output logic                               res_valid,
	output tpd_pkg::result_t                   res,
	output logic [tpd_pkg::IDX_W-1:0]          sample_index,
	output logic                               in_run,
	output logic                               limit_hit
);

	logic                      in_run_q, in_run_d;
	logic [tpd_pkg::IDX_W-1:0] run_start_q, run_start_d;
	logic [tpd_pkg::IDX_W-1:0] run_stop_q, run_stop_d;
	logic [tpd_pkg::IDX_W-1:0] index_q, index_d;
	logic [tpd_pkg::CNT_W-1:0] count_q, count_d;
	logic                      limit_q, limit_d;

	logic [tpd_pkg::CNT_W-1:0] limit;
	logic [tpd_pkg::IDX_W-1:0] run_w;
	logic [tpd_pkg::IDX_W:0]   run_sum;
	logic                      found;

	always_comb begin
		if (cfg.peak_quota == '0)
			limit = tpd_pkg::CNT_W'(1);
		else if (cfg.peak_quota > tpd_pkg::LIMIT_MAX)
			limit = tpd_pkg::LIMIT_MAX;
		else
			limit = cfg.peak_quota;
	end

	assign run_w   = run_stop_q - run_start_q;
	assign run_sum = {1'b0, run_start_q} + {1'b0, run_stop_q};

	always_comb begin
		in_run_d    = in_run_q;
		run_start_d = run_start_q;
		run_stop_d  = run_stop_q;
		index_d     = index_q;
		count_d     = count_q;
		limit_d     = limit_q;
		found       = 1'b0;

		if (!limit_q) begin
			if (sample >= cfg.height_thr) begin
				if (!in_run_q)
					run_start_d = index_q;
				in_run_d   = 1'b1;
				run_stop_d = index_q;
			end else if (in_run_q) begin
				if (run_stop_q >= run_start_q && run_w >= cfg.min_run_width) begin
					found   = 1'b1;
					count_d = count_q + tpd_pkg::CNT_W'(1);
					if (count_d >= limit)
						limit_d = 1'b1;
				end else begin
					run_stop_d = '0;
				end
				in_run_d = 1'b0;
			end
			if (index_q < tpd_pkg::IDX_CAP)
				index_d = index_q + tpd_pkg::IDX_W'(1);
		end

		res_valid         = found | last_sample;
		res.peak_found    = found;
		res.peak_center   = found ? run_sum[tpd_pkg::IDX_W:1] : '0;
		res.peak_width    = found ? run_w : '0;
		res.peak_count    = count_d;
		res.limit_reached = limit_d;
		res.frame_end     = last_sample;

		// clear the frame after its last sample; an open run is dropped
		if (last_sample) begin
			in_run_d    = 1'b0;
			run_start_d = '0;
			run_stop_d  = '0;
			index_d     = '0;
			count_d     = '0;
			limit_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q    <= 1'b0;
			run_start_q <= '0;
			run_stop_q  <= '0;
			index_q     <= '0;
			count_q     <= '0;
			limit_q     <= 1'b0;
		end else if (fire) begin
			in_run_q    <= in_run_d;
			run_start_q <= run_start_d;
			run_stop_q  <= run_stop_d;
			index_q     <= index_d;
			count_q     <= count_d;
			limit_q     <= limit_d;
		end
	end

	assign sample_index = index_q;
	assign in_run       = in_run_q;
	assign limit_hit    = limit_q;

endmodule

### src/tpd_out_reg.sv
// Result register that drives the peak result channel.
module tpd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tpd_pkg::result_t res,
	output logic             free,
	tpd_peak_if.source       peaks
);

	logic             valid_q;
	tpd_pkg::result_t res_q;

	assign free = !valid_q || peaks.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (free)
			valid_q <= load;
	end

	always_ff @(posedge clk) begin
		if (free && load)
			res_q <= res;
	end

	assign peaks.valid         = valid_q;
	assign peaks.peak_found    = res_q.peak_found;
	assign peaks.peak_center   = res_q.peak_center;
	assign peaks.peak_width    = res_q.peak_width;
	assign peaks.peak_count    = res_q.peak_count;
	assign peaks.limit_reached = res_q.limit_reached;
	assign peaks.frame_end     = res_q.frame_end;

endmodule

### src/threshold_peak_detector_top.sv
// Threshold peak detector with minimum run width: top level.
//
// Samples enter on the samples channel, one per transaction, with last_sample
// marking the end of a frame. A result leaves on the peaks channel for each
// accepted peak and for every last sample (frame_end = 1, with the count).
// Samples that neither close an accepted peak nor end a frame give no result.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata:
// index 0 height threshold, 1 min_run_width, 2 peak limit; write only while idle.
// A result passes through two registers: the sample's transaction loads the input
// register, and the state update then loads the result register unless the
// receiver stalls. Throughput: one sample per cycle while the receiver does
// not stall.
// When the receiver stalls, the result register holds and the input register
// keeps at most one more sample; ready then drops until the result is taken.
// Reset clears the frame state, empties both registers and loads
// threshold 0, min_run_width 0 and a peak limit of 64.
`include "threshold_peak_detector_top_assert.svh"

module threshold_peak_detector_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tpd_sample_if.sink                     samples,
	tpd_peak_if.source                     peaks
);

	tpd_pkg::cfg_t    cfg;
	tpd_pkg::result_t res;
	logic             res_valid;
	logic             free;
	logic             fire;

	logic                                valid_s1;
	logic signed [tpd_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                last_s1;

	logic [tpd_pkg::IDX_W-1:0] sample_index;
	logic                      in_run;
	logic                      limit_hit;

	tpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign samples.ready = !valid_s1 || free;
	assign fire          = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (samples.ready)
			valid_s1 <= samples.valid;
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			sample_s1 <= samples.sample;
			last_s1   <= samples.last_sample;
		end
	end

	tpd_detect u_detect (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.fire         (fire),
		.sample       (sample_s1),
		.last_sample  (last_s1),
		.res_valid    (res_valid),
		.res          (res),
		.sample_index (sample_index),
		.in_run       (in_run),
		.limit_hit    (limit_hit)
	);

	tpd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire && res_valid),
		.res    (res),
		.free   (free),
		.peaks  (peaks)
	);

	// a frame that hit its limit has no run open
	`TPD_ASSERT_IMP(a_limit_no_run, limit_hit, !in_run)
	// the frame state starts over after the last sample
	`TPD_ASSERT_NXT(a_frame_clear, fire && last_s1, sample_index == '0 && !limit_hit)
	// twice the center of a run reaches at least its width less one
	`TPD_ASSERT_IMP(a_center_width, peaks.valid && peaks.peak_found,
		({1'b0, peaks.peak_center, 1'b0} + 16'd1) >= {2'b00, peaks.peak_width})
	// a result without a peak carries no peak geometry and ends a frame
	`TPD_ASSERT_IMP(a_no_peak_zero, peaks.valid && !peaks.peak_found,
		peaks.peak_center == '0 && peaks.peak_width == '0 && peaks.frame_end)

endmodule

### sim/tb_threshold_peak_detector_top.sv
// Testbench for the threshold peak detector: directed table, then random frames.
`timescale 1ns / 1ps

module tb_threshold_peak_detector_top;

	localparam int NO_WRITE     = -1;
	localparam int SETTLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_ITEMS = 926;

	typedef enum logic [1:0] {BY_MODEL, NO_REPORT, GIVEN_REPORT} row_check_t;

	typedef struct {
		int                                  preset;
		logic signed [tpd_pkg::SAMPLE_W-1:0] level;
		bit                                  last;
		row_check_t                          how;
		tpd_pkg::result_t                    given;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tpd_pkg::CFG_DATA_W-1:0] cfg_wdata;

	tpd_sample_if sample_ch();
	tpd_peak_if   peak_ch();

	threshold_peak_detector_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (sample_ch),
		.peaks     (peak_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the configuration and of the frame state
	logic signed [tpd_pkg::SAMPLE_W-1:0] height_floor = '0;
	logic [tpd_pkg::IDX_W-1:0]           width_floor  = '0;
	logic [tpd_pkg::CNT_W-1:0]           peak_cap     = tpd_pkg::PEAK_QUOTA_RST;
	bit                                  run_open       = 1'b0;
	logic [tpd_pkg::IDX_W-1:0]           run_first      = '0;
	logic [tpd_pkg::IDX_W-1:0]           run_last       = '0;
	logic [tpd_pkg::IDX_W-1:0]           idx_now        = '0;
	logic [tpd_pkg::CNT_W-1:0]           peaks_in_frame = '0;
	bit                                  frame_capped   = 1'b0;

	tpd_pkg::result_t reports_due [$];
	bit      source_calm = 1'b0;
	bit      sink_calm   = 1'b0;
	int      mismatches  = 0;
	int      samples_sent = 0;
	int      frames_seen  = 0;
	int      peaks_seen   = 0;
	int      capped_frames = 0;
	int      settings_used = 0;
	int      widest_peak   = 0;

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// Advance the frame state by one sample; return 1 when a report is due
	function automatic bit detect_sample(input logic signed [tpd_pkg::SAMPLE_W-1:0] level,
			input bit last, output tpd_pkg::result_t rep);
		logic [tpd_pkg::CNT_W-1:0] cap;
		logic [tpd_pkg::IDX_W-1:0] span;
		bit                        found;
		found = 1'b0;
		rep = '0;
		cap = (peak_cap == '0) ? tpd_pkg::CNT_W'(1) :
			((peak_cap > tpd_pkg::LIMIT_MAX) ? tpd_pkg::LIMIT_MAX : peak_cap);
		if (!frame_capped) begin
			if (level >= height_floor) begin
				if (!run_open) begin
					run_open = 1'b1;
					run_first = idx_now;
				end
				run_last = idx_now;
			end else if (run_open) begin
				span = run_last - run_first;
				if (run_last >= run_first && span >= width_floor) begin
					found = 1'b1;
					rep.peak_center = tpd_pkg::IDX_W'(({1'b0, run_first} +
						{1'b0, run_last}) >> 1);
					rep.peak_width = span;
					peaks_in_frame++;
					if (peaks_in_frame >= cap)
						frame_capped = 1'b1;
				end else begin
					run_last = '0;
				end
				run_open = 1'b0;
			end
			if (idx_now < tpd_pkg::IDX_CAP)
				idx_now++;
		end
		rep.peak_found = found;
		rep.peak_count = peaks_in_frame;
		rep.limit_reached = frame_capped;
		rep.frame_end = last;
		if (last) begin
			run_open = 1'b0;
			run_first = '0;
			run_last = '0;
			idx_now = '0;
			peaks_in_frame = '0;
			frame_capped = 1'b0;
		end
		return found || last;
	endfunction

	function automatic tpd_pkg::result_t peak_report(input bit found, input int center,
			input int span, input int count, input bit capped, input bit last);
		tpd_pkg::result_t rep;
		rep.peak_found = found;
		rep.peak_center = tpd_pkg::IDX_W'(center);
		rep.peak_width = tpd_pkg::IDX_W'(span);
		rep.peak_count = tpd_pkg::CNT_W'(count);
		rep.limit_reached = capped;
		rep.frame_end = last;
		return rep;
	endfunction

	function automatic stim_row_t stim_row(input int preset, input int level, input bit last,
			input row_check_t how = BY_MODEL, input tpd_pkg::result_t given = '0);
		stim_row_t r;
		r.preset = preset;
		r.level = tpd_pkg::SAMPLE_W'(level);
		r.last = last;
		r.how = how;
		r.given = given;
		return r;
	endfunction

	function automatic logic signed [tpd_pkg::SAMPLE_W-1:0] level_between(input int lo,
			input int hi);
		return tpd_pkg::SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	// Hold valid across back-to-back transactions; drop it only for a gap
	task automatic send_sample(input logic signed [tpd_pkg::SAMPLE_W-1:0] level,
			input bit last, input row_check_t how = BY_MODEL,
			input tpd_pkg::result_t given = '0);
		int               gap;
		tpd_pkg::result_t rep;
		gap = source_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= level;
		sample_ch.last_sample <= last;
		do @(posedge clk); while (!sample_ch.ready);
		samples_sent++;
		case (how)
			BY_MODEL: begin
				if (detect_sample(level, last, rep))
					reports_due.push_back(rep);
			end
			GIVEN_REPORT: begin
				void'(detect_sample(level, last, rep));
				reports_due.push_back(given);
			end
			default: void'(detect_sample(level, last, rep));
		endcase
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input tpd_pkg::cfg_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= tpd_pkg::REG_HEIGHT_THR;
		cfg_wdata <= tpd_pkg::CFG_DATA_W'(c.height_thr);
		@(posedge clk);
		cfg_index <= tpd_pkg::REG_MIN_RUN_WIDTH;
		cfg_wdata <= tpd_pkg::CFG_DATA_W'(c.min_run_width);
		@(posedge clk);
		cfg_index <= tpd_pkg::REG_PEAK_QUOTA;
		cfg_wdata <= tpd_pkg::CFG_DATA_W'(c.peak_quota);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		height_floor = c.height_thr;
		width_floor = c.min_run_width;
		peak_cap = c.peak_quota;
		settings_used++;
	endtask

	// Result side: stall for a drawn number of cycles before each transaction
	initial begin : result_sink
		int stall;
		peak_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				peak_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			peak_ch.ready <= 1'b1;
			do @(posedge clk); while (!peak_ch.valid);
		end
	end

	always @(posedge clk) begin : check_results
		tpd_pkg::result_t want;
		if (arst_n && peak_ch.valid && peak_ch.ready) begin
			if (reports_due.size() == 0) begin
				note_mismatch("result transaction with no report expected");
			end else begin
				want = reports_due.pop_front();
				if (peak_ch.peak_found !== want.peak_found)
					note_mismatch($sformatf("peak_found %0b, expected %0b",
						peak_ch.peak_found, want.peak_found));
				if (peak_ch.peak_center !== want.peak_center)
					note_mismatch($sformatf("peak_center %0d, expected %0d",
						peak_ch.peak_center, want.peak_center));
				if (peak_ch.peak_width !== want.peak_width)
					note_mismatch($sformatf("peak_width %0d, expected %0d",
						peak_ch.peak_width, want.peak_width));
				if (peak_ch.peak_count !== want.peak_count)
					note_mismatch($sformatf("peak_count %0d, expected %0d",
						peak_ch.peak_count, want.peak_count));
				if (peak_ch.limit_reached !== want.limit_reached)
					note_mismatch($sformatf("limit_reached %0b, expected %0b",
						peak_ch.limit_reached, want.limit_reached));
				if (peak_ch.frame_end !== want.frame_end)
					note_mismatch($sformatf("frame_end %0b, expected %0b",
						peak_ch.frame_end, want.frame_end));
				if (want.peak_found) begin
					peaks_seen++;
					if (int'(want.peak_width) > widest_peak)
						widest_peak = int'(want.peak_width);
				end
				if (want.frame_end) begin
					frames_seen++;
					if (want.limit_reached)
						capped_frames++;
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t                           directed_rows [$];
		tpd_pkg::cfg_t                       directed_presets [2];
		tpd_pkg::cfg_t                       c;
		logic signed [tpd_pkg::SAMPLE_W-1:0] level;
		bit                                  above;
		int                                  k;
		int                                  len;
		int                                  settle;
		int                                  phase;
		int                                  random_sent;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.last_sample = 1'b0;

		directed_presets[0] = '{16'sd10, 14'd2, 7'd0};
		directed_presets[1] = '{16'sd32767, 14'd16383, 7'd127};
		directed_rows = {
			// reset settings: threshold 0, any width, 64 peaks
			stim_row(NO_WRITE, 0, 1'b0),
			stim_row(NO_WRITE, -1, 1'b0, GIVEN_REPORT, peak_report(1, 0, 0, 1, 0, 0)),
			stim_row(NO_WRITE, 32767, 1'b0),
			stim_row(NO_WRITE, 32767, 1'b0),
			stim_row(NO_WRITE, -32768, 1'b0, GIVEN_REPORT, peak_report(1, 2, 1, 2, 0, 0)),
			stim_row(NO_WRITE, -32768, 1'b1, GIVEN_REPORT, peak_report(0, 0, 0, 2, 0, 1)),
			// peak closed by the last sample
			stim_row(NO_WRITE, 100, 1'b0),
			stim_row(NO_WRITE, -5, 1'b1, GIVEN_REPORT, peak_report(1, 0, 0, 1, 0, 1)),
			// run still open at frame end is dropped
			stim_row(NO_WRITE, 5, 1'b0),
			stim_row(NO_WRITE, 6, 1'b1, GIVEN_REPORT, peak_report(0, 0, 0, 0, 0, 1)),
			stim_row(NO_WRITE, -1, 1'b1, GIVEN_REPORT, peak_report(0, 0, 0, 0, 0, 1)),
			// short run rejected, then limit of zero acting as one
			stim_row(0, 10, 1'b0),
			stim_row(NO_WRITE, 11, 1'b0),
			stim_row(NO_WRITE, 9, 1'b0, NO_REPORT),
			stim_row(NO_WRITE, 20, 1'b0),
			stim_row(NO_WRITE, 20, 1'b0),
			stim_row(NO_WRITE, 20, 1'b0),
			stim_row(NO_WRITE, 0, 1'b0, GIVEN_REPORT, peak_report(1, 4, 2, 1, 1, 0)),
			stim_row(NO_WRITE, 50, 1'b0, NO_REPORT),
			stim_row(NO_WRITE, 0, 1'b0, NO_REPORT),
			stim_row(NO_WRITE, 50, 1'b1, GIVEN_REPORT, peak_report(0, 0, 0, 1, 1, 1)),
			// top threshold, widest minimum, oversized limit
			stim_row(1, 32767, 1'b0),
			stim_row(NO_WRITE, 32766, 1'b0, NO_REPORT),
			stim_row(NO_WRITE, 0, 1'b1, GIVEN_REPORT, peak_report(0, 0, 0, 0, 0, 1))
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].preset != NO_WRITE) begin
				wait_drained();
				write_config(directed_presets[directed_rows[i].preset]);
			end
			send_sample(directed_rows[i].level, directed_rows[i].last,
				directed_rows[i].how, directed_rows[i].given);
		end

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_drained();
			case ($urandom_range(0, 9))
				0: c.height_thr = 16'sh8000;
				1: c.height_thr = 16'sh7fff;
				2: c.height_thr = '0;
				3: c.height_thr = tpd_pkg::SAMPLE_W'($urandom);
				default: c.height_thr = level_between(-1000, 1000);
			endcase
			if (phase == 0)
				c.height_thr = 16'sh8000;
			case ($urandom_range(0, 9)) inside
				[0:2]: c.min_run_width = '0;
				3: c.min_run_width = 14'd16383;
				4: c.min_run_width = tpd_pkg::IDX_W'($urandom_range(0, 16383));
				default: c.min_run_width = tpd_pkg::IDX_W'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 9))
				0: c.peak_quota = '0;
				1: c.peak_quota = 7'd127;
				2: c.peak_quota = tpd_pkg::LIMIT_MAX;
				3: c.peak_quota = tpd_pkg::CNT_W'($urandom_range(65, 126));
				4: c.peak_quota = tpd_pkg::CNT_W'($urandom_range(0, 127));
				default: c.peak_quota = tpd_pkg::CNT_W'($urandom_range(1, 6));
			endcase
			write_config(c);
			source_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) :
					$urandom_range(1, 30);
				// keep the total near the planned item count; frames stay whole
				if (len > RANDOM_ITEMS - random_sent)
					len = RANDOM_ITEMS - random_sent;
				above = $urandom_range(0, 1);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 3) == 0)
						above = !above;
					if ($urandom_range(0, 7) == 0)
						level = tpd_pkg::SAMPLE_W'($urandom);
					else if (above || height_floor == 16'sh8000)
						level = level_between(int'(height_floor), 32767);
					else
						level = level_between(-32768, int'(height_floor) - 1);
					send_sample(level, k == len - 1);
					random_sent++;
					if ($urandom_range(0, 39) == 0)
						wait_drained();
				end
			end
			phase++;
		end

		sample_ch.valid <= 1'b0;
		settle = 0;
		while (reports_due.size() != 0 && settle < SETTLE_LIMIT) begin
			@(posedge clk);
			settle++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (reports_due.size() != 0)
			note_mismatch($sformatf("%0d expected reports never arrived", reports_due.size()));

		$display("Sent %0d samples over %0d frames under %0d register settings.",
			samples_sent, frames_seen, settings_used);
		$display("Checked %0d peaks (widest %0d), %0d frames stopped at the peak limit.",
			peaks_seen, widest_peak, capped_frames);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### threshold_peak_detector_top.f
+incdir+src
src/tpd_pkg.sv
src/tpd_if.sv
src/tpd_cfg.sv
src/tpd_detect.sv
src/tpd_out_reg.sv
src/threshold_peak_detector_top.sv
sim/tb_threshold_peak_detector_top.sv
